/* rtl/adaptive_traffic_light_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive traffic light
// Shared wrappers that keep clocking and reset handling the same everywhere.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_TRAFFIC_LIGHT_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_LIGHT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/atl_pkg.sv */
// ---------------------------------------------------------------------------
// Adaptive traffic light package
// Types, codes and timing constants shared by the signal controller files.
// ---------------------------------------------------------------------------
`default_nettype none

package atl_pkg;

   localparam int COUNT_MAX = 255;
   localparam logic [7:0] COUNT_CAP = 8'((COUNT_MAX > 255) ? 255 : COUNT_MAX);

   localparam int TIMER_W = 18;
   localparam int MS_W    = 16;
   localparam int TICK_W  = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register reset values in milliseconds.
   localparam logic [MS_W-1:0] GREEN_RESET_MS  = 16'd7000;
   localparam logic [MS_W-1:0] YELLOW_RESET_MS = 16'd2000;
   localparam logic [MS_W-1:0] RED_RESET_MS    = 16'd9000;

   // Lengths chosen at each cycle wrap from the waiting count.
   localparam logic [7:0] WAIT_BUSY = 8'd5;
   localparam logic [7:0] WAIT_MID  = 8'd3;
   localparam logic [MS_W-1:0] GREEN_BUSY_MS = 16'd10000;
   localparam logic [MS_W-1:0] RED_BUSY_MS   = 16'd8000;
   localparam logic [MS_W-1:0] GREEN_MID_MS  = 16'd8000;
   localparam logic [MS_W-1:0] RED_MID_MS    = 16'd9000;
   localparam logic [MS_W-1:0] GREEN_IDLE_MS = 16'd7000;
   localparam logic [MS_W-1:0] RED_IDLE_MS   = 16'd9000;

   localparam int ENTER_MARGIN_MS = 500;

   typedef enum logic [1:0] {
      ASPECT_GREEN  = 2'd0,
      ASPECT_YELLOW = 2'd1,
      ASPECT_RED    = 2'd2
   } aspect_type;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_ARRIVE = 2'd1,
      KIND_LEAVE  = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_GREEN  = 3'd1,
      CSR_YELLOW = 3'd2,
      CSR_RED    = 3'd3,
      CSR_OFFSET = 3'd4
   } csr_index_type;

   // Command from the register block that an enable write issues to the core.
   typedef struct packed {
      logic               valid;
      logic               enable;
      logic               timer_load;
      logic [TIMER_W-1:0] timer;
      logic [MS_W-1:0]    green;
      logic [MS_W-1:0]    red;
   } load_type;

   typedef struct packed {
      logic [1:0] light;
      logic       may_enter;
      logic [7:0] waiting;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/atl_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one input beat: kind and tick length.
// ---------------------------------------------------------------------------
`default_nettype none

interface atl_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [atl_pkg::TICK_W-1:0] tick_ms;

   modport source (output valid, kind, tick_ms, input ready);
   modport sink   (input valid, kind, tick_ms, output ready);
endinterface

`default_nettype wire

/* rtl/atl_rsp_if.sv */
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat: aspect, permission, count.
// ---------------------------------------------------------------------------
`default_nettype none

interface atl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] light;
   logic       may_enter;
   logic [7:0] waiting;

   modport source (output valid, light, may_enter, waiting, input ready);
   modport sink   (input valid, light, may_enter, waiting, output ready);
endinterface

`default_nettype wire

/* rtl/atl_csr_if.sv */
// ---------------------------------------------------------------------------
// Register write channel
// Valid/ready channel that carries a register index and its write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface atl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [atl_pkg::CSR_INDEX_W-1:0] index;
   logic [atl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/atl_csr.sv */
// ---------------------------------------------------------------------------
// Register block
// Holds the timing registers and turns an enable write into a load command.
// ---------------------------------------------------------------------------
`default_nettype none

module atl_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   atl_csr_if.sink               csr_chan,
   output logic [atl_pkg::MS_W-1:0] yellow_ms,
   output atl_pkg::load_type     load
);

   logic [atl_pkg::MS_W-1:0] green_ff, green_in;
   logic [atl_pkg::MS_W-1:0] yellow_ff, yellow_in;
   logic [atl_pkg::MS_W-1:0] red_ff, red_in;
   logic [7:0]               offset_ff, offset_in;
   atl_pkg::load_type        load_ff, load_in;

   logic                         write;
   logic [atl_pkg::TIMER_W-1:0]  cycle;
   logic [atl_pkg::TIMER_W+7:0]  product;

   assign csr_chan.ready = 1'b1;
   assign write = csr_chan.valid && csr_chan.ready;

   // Start point of the cycle as offset/256 of the cycle length that the
   // enable write is about to load.
   assign cycle   = {2'b00, green_ff} + {2'b00, yellow_ff} + {2'b00, red_ff};
   assign product = {18'd0, offset_ff} * {8'd0, cycle};

   always_comb begin
      green_in  = green_ff;
      yellow_in = yellow_ff;
      red_in    = red_ff;
      offset_in = offset_ff;
      load_in            = load_ff;
      load_in.valid      = 1'b0;
      if (write) begin
         unique case (atl_pkg::csr_index_type'(csr_chan.index))
            atl_pkg::CSR_ENABLE: begin
               load_in.valid      = 1'b1;
               load_in.enable     = csr_chan.data[0];
               load_in.timer_load = csr_chan.data[0] && (offset_ff != 8'd0);
               load_in.timer      = product[atl_pkg::TIMER_W+7:8];
               load_in.green      = green_ff;
               load_in.red        = red_ff;
            end
            atl_pkg::CSR_GREEN:  green_in  = csr_chan.data;
            atl_pkg::CSR_YELLOW: yellow_in = csr_chan.data;
            atl_pkg::CSR_RED:    red_in    = csr_chan.data;
            atl_pkg::CSR_OFFSET: offset_in = csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff      <= atl_pkg::GREEN_RESET_MS;
         yellow_ff     <= atl_pkg::YELLOW_RESET_MS;
         red_ff        <= atl_pkg::RED_RESET_MS;
         offset_ff     <= 8'd0;
         load_ff.valid <= 1'b0;
      end else begin
         green_ff  <= green_in;
         yellow_ff <= yellow_in;
         red_ff    <= red_in;
         offset_ff <= offset_in;
         load_ff   <= load_in;
      end
   end

   assign yellow_ms = yellow_ff;
   assign load      = load_ff;

endmodule

`default_nettype wire

/* rtl/atl_core.sv */
// ---------------------------------------------------------------------------
// Signal core
// Cycle timer, aspect, wait count, current lengths; one beat per accept cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module atl_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [1:0]                 kind,
   input  wire logic [atl_pkg::TICK_W-1:0] tick_ms,
   input  wire logic [atl_pkg::MS_W-1:0]   yellow_ms,
   input  wire atl_pkg::load_type          load,
   output atl_pkg::rsp_type                result
);

   logic                        enable_ff, enable_in;
   logic [atl_pkg::TIMER_W-1:0] timer_ff, timer_in;
   atl_pkg::aspect_type         aspect_ff, aspect_in;
   logic [7:0]                  count_ff, count_in;
   logic [atl_pkg::MS_W-1:0]    green_ff, green_in;
   logic [atl_pkg::MS_W-1:0]    red_ff, red_in;

   logic [atl_pkg::TIMER_W-1:0] cycle;
   logic [atl_pkg::TIMER_W-1:0] t_sum;
   logic [atl_pkg::MS_W-1:0]    green_next, red_next;
   logic [atl_pkg::MS_W:0]      yellow_end;
   logic signed [atl_pkg::TIMER_W:0] left;

   function automatic atl_pkg::aspect_type derive_aspect(
      input logic [atl_pkg::TIMER_W-1:0] t,
      input logic [atl_pkg::MS_W-1:0]    g,
      input logic [atl_pkg::MS_W-1:0]    y
   );
      logic [atl_pkg::MS_W:0] g_end;
      atl_pkg::aspect_type    a;
      g_end = {1'b0, g} + {1'b0, y};
      if (t < {2'b00, g})
         a = atl_pkg::ASPECT_GREEN;
      else if (t < {1'b0, g_end})
         a = atl_pkg::ASPECT_YELLOW;
      else
         a = atl_pkg::ASPECT_RED;
      return a;
   endfunction

   assign cycle = {2'b00, green_ff} + {2'b00, yellow_ms} + {2'b00, red_ff};
   assign t_sum = timer_ff + {8'd0, tick_ms};

   always_comb begin
      if (count_ff > atl_pkg::WAIT_BUSY) begin
         green_next = atl_pkg::GREEN_BUSY_MS;
         red_next   = atl_pkg::RED_BUSY_MS;
      end else if (count_ff > atl_pkg::WAIT_MID) begin
         green_next = atl_pkg::GREEN_MID_MS;
         red_next   = atl_pkg::RED_MID_MS;
      end else begin
         green_next = atl_pkg::GREEN_IDLE_MS;
         red_next   = atl_pkg::RED_IDLE_MS;
      end
   end

   always_comb begin
      enable_in = enable_ff;
      timer_in  = timer_ff;
      aspect_in = aspect_ff;
      count_in  = count_ff;
      green_in  = green_ff;
      red_in    = red_ff;
      if (load.valid) begin
         enable_in = load.enable;
         green_in  = load.green;
         red_in    = load.red;
         if (load.timer_load) begin
            timer_in  = load.timer;
            aspect_in = derive_aspect(load.timer, load.green, yellow_ms);
         end
      end else if (accept) begin
         case (atl_pkg::kind_type'(kind))
            atl_pkg::KIND_TICK: begin
               if (enable_ff) begin
                  // At most one cycle length is taken off per tick.
                  if (t_sum >= cycle) begin
                     timer_in = t_sum - cycle;
                     green_in = green_next;
                     red_in   = red_next;
                  end else begin
                     timer_in = t_sum;
                  end
                  aspect_in = derive_aspect(timer_in, green_in, yellow_ms);
               end
            end
            atl_pkg::KIND_ARRIVE: begin
               if (count_ff < atl_pkg::COUNT_CAP)
                  count_in = count_ff + 8'd1;
            end
            atl_pkg::KIND_LEAVE: begin
               if (count_ff != 8'd0)
                  count_in = count_ff - 8'd1;
            end
            default: ;
         endcase
      end
   end

   assign yellow_end = {1'b0, green_in} + {1'b0, yellow_ms};
   assign left = $signed({2'b00, yellow_end}) - $signed({1'b0, timer_in});

   always_comb begin
      result.waiting = count_in;
      if (!enable_ff) begin
         result.light     = atl_pkg::ASPECT_GREEN;
         result.may_enter = 1'b1;
      end else begin
         result.light = aspect_in;
         case (aspect_in)
            atl_pkg::ASPECT_GREEN:  result.may_enter = 1'b1;
            atl_pkg::ASPECT_YELLOW:
               result.may_enter = left > (atl_pkg::TIMER_W+1)'(atl_pkg::ENTER_MARGIN_MS);
            default:                result.may_enter = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         timer_ff  <= '0;
         aspect_ff <= atl_pkg::ASPECT_GREEN;
         count_ff  <= 8'd0;
         green_ff  <= atl_pkg::GREEN_RESET_MS;
         red_ff    <= atl_pkg::RED_RESET_MS;
      end else begin
         enable_ff <= enable_in;
         timer_ff  <= timer_in;
         aspect_ff <= aspect_in;
         count_ff  <= count_in;
         green_ff  <= green_in;
         red_ff    <= red_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/atl_skid.sv */
// ---------------------------------------------------------------------------
// Result buffer
// Two-entry output register so a new beat is taken while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module atl_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire atl_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output atl_pkg::rsp_type      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   atl_pkg::rsp_type main_ff, main_in;
   atl_pkg::rsp_type skid_ff, skid_in;
   logic             push;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         // Output is stalled: park the new beat behind it.
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

/* rtl/adaptive_traffic_light.sv */
// ---------------------------------------------------------------------------
// Adaptive traffic light
// Three-aspect signal controller with a millisecond cycle timer.
// ---------------------------------------------------------------------------
// The block takes one request beat per clock cycle while req_chan.ready is
// high (tick, arrival, departure or query) and returns exactly one response
// beat for each through a two-entry output buffer, so requests keep flowing
// while a response waits. Ready is low while both entries are full and while
// the load command of an enable write is applied; the cycle timer then takes
// the offset-times-cycle product if the offset is non-zero. Register writes
// are always accepted and belong in idle periods. There is no clearing pass.
`default_nettype none

`include "adaptive_traffic_light_defines.svh"

module adaptive_traffic_light (
   input wire logic clock,
   input wire logic reset,
   atl_req_if.sink   req_chan,
   atl_rsp_if.source rsp_chan,
   atl_csr_if.sink   csr_chan
);

   logic [atl_pkg::MS_W-1:0] yellow_ms;
   atl_pkg::load_type        load;
   atl_pkg::rsp_type         result;
   atl_pkg::rsp_type         out_data;
   logic                     buf_ready;
   logic                     accept;

   assign req_chan.ready = buf_ready && !load.valid;
   assign accept         = req_chan.valid && req_chan.ready;

   atl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .yellow_ms (yellow_ms),
      .load      (load)
   );

   atl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_chan.kind),
      .tick_ms   (req_chan.tick_ms),
      .yellow_ms (yellow_ms),
      .load      (load),
      .result    (result)
   );

   atl_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.light     = out_data.light;
   assign rsp_chan.may_enter = out_data.may_enter;
   assign rsp_chan.waiting   = out_data.waiting;

   `ATL_ASSERT_SAME(a_no_accept_during_load, clock, reset, load.valid, !req_chan.ready, "request accepted while a timer load is pending")
   `ATL_ASSERT_SAME(a_red_blocks_entry, clock, reset, rsp_chan.valid && (rsp_chan.light == atl_pkg::ASPECT_RED), !rsp_chan.may_enter, "entry permitted on red")
   `ATL_ASSERT_NEXT(a_accept_gives_response, clock, reset, accept, rsp_chan.valid, "accepted request produced no response")

endmodule

`default_nettype wire
